[rtl/core/hms_pkg.sv]
// ----------------------------------------------------------------------------
// hms_pkg: shared types, constants and helpers for the hh:mm:ss timer block
// Transaction payloads, timer state and the one-second count functions.
// ----------------------------------------------------------------------------
package hms_pkg;

  localparam int unsigned TICKS_PER_SECOND = 1000;
  localparam int unsigned MS_W = (TICKS_PER_SECOND > 2) ? $clog2(TICKS_PER_SECOND) : 1;
  localparam logic [MS_W-1:0] MS_LAST = MS_W'(TICKS_PER_SECOND - 1);

  localparam logic [5:0] SEC_MAX  = 6'd59;
  localparam logic [5:0] MIN_MAX  = 6'd59;
  localparam logic [6:0] HOUR_MAX = 7'd23;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_CTRL = 2'd1,
    OP_LOAD = 2'd2,
    OP_READ = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    TM_UP   = 2'd0,
    TM_DOWN = 2'd1,
    TM_P1   = 2'd2,
    TM_P2   = 2'd3
  } tsel_e;

  typedef enum logic [1:0] {
    TURN_P1      = 2'd0,
    TURN_P2      = 2'd1,
    TURN_IDLE    = 2'd2,
    TURN_EXPIRED = 2'd3
  } turn_e;

  typedef struct packed {
    op_e        operation;
    tsel_e      timer_select;
    logic [6:0] load_hours;
    logic [5:0] load_minutes;
    logic [5:0] load_seconds;
    logic       set_countup_run;
    logic       set_countdown_run;
    turn_e      set_turn;
    logic       set_alarm;
  } hms_in_t;

  typedef struct packed {
    logic [6:0] out_hours;
    logic [5:0] out_minutes;
    logic [5:0] out_seconds;
    logic       alarm_active;
    logic       led_on;
    logic       countdown_running;
    turn_e      turn_now;
    logic       second_elapsed;
  } hms_out_t;

  typedef struct packed {
    logic [6:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
  } hms_time_t;

  typedef struct packed {
    logic [MS_W-1:0]     ms;
    hms_time_t [3:0]     timer;
    logic                cu_run;
    logic                cd_run;
    turn_e               turn;
    logic                alarm;
    logic                led;
  } hms_state_t;

  typedef struct packed {
    hms_time_t t;
    logic      zero;
  } hms_dec_t;

  // Decrement by one second; flag a timer already at zero and hold it.
  function automatic hms_dec_t count_down(hms_time_t t);
    hms_dec_t r;
    r.t    = t;
    r.zero = 1'b0;
    if (t.seconds != '0) begin
      r.t.seconds = t.seconds - 6'd1;
    end else if (t.minutes != '0) begin
      r.t.seconds = SEC_MAX;
      r.t.minutes = t.minutes - 6'd1;
    end else if (t.hours != '0) begin
      r.t.seconds = SEC_MAX;
      r.t.minutes = MIN_MAX;
      r.t.hours   = t.hours - 7'd1;
    end else begin
      r.zero = 1'b1;
    end
    return r;
  endfunction

  // Advance by one second, wrap after 23:59:59.
  function automatic hms_time_t count_up(hms_time_t t);
    hms_time_t r;
    r = t;
    if (t.seconds < SEC_MAX) begin
      r.seconds = t.seconds + 6'd1;
    end else begin
      r.seconds = '0;
      if (t.minutes < MIN_MAX) begin
        r.minutes = t.minutes + 6'd1;
      end else begin
        r.minutes = '0;
        r.hours   = (t.hours < HOUR_MAX) ? t.hours + 7'd1 : '0;
      end
    end
    return r;
  endfunction

endpackage

[rtl/core/hms_in_if.sv]
// ----------------------------------------------------------------------------
// hms_in_if: request channel of the timer block
// Valid/ready channel carrying one request transaction.
// ----------------------------------------------------------------------------
interface hms_in_if;
  logic             valid;
  logic             ready;
  hms_pkg::hms_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/hms_out_if.sv]
// ----------------------------------------------------------------------------
// hms_out_if: response channel of the timer block
// Valid/ready channel carrying one response transaction.
// ----------------------------------------------------------------------------
interface hms_out_if;
  logic              valid;
  logic              ready;
  hms_pkg::hms_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/hms_step.sv]
// ----------------------------------------------------------------------------
// hms_step: next-state and response logic of the timer block
// Applies one request to the timer state: tick prescaler, second boundary,
// control write, time load or readback.
// ----------------------------------------------------------------------------
module hms_step (
  input  logic               fire_i,
  input  hms_pkg::hms_in_t    item_i,
  input  hms_pkg::hms_state_t state_i,
  output hms_pkg::hms_state_t state_o,
  output hms_pkg::hms_out_t   result_o
);
  import hms_pkg::*;

  hms_state_t nxt;
  hms_dec_t   dn;
  hms_dec_t   p1;
  hms_dec_t   p2;
  hms_time_t  up;
  hms_time_t  sel_t;
  logic       sec;

  assign dn = count_down(state_i.timer[TM_DOWN]);
  assign p1 = count_down(state_i.timer[TM_P1]);
  assign p2 = count_down(state_i.timer[TM_P2]);
  assign up = count_up(state_i.timer[TM_UP]);

  always_comb begin
    nxt = state_i;
    sec = 1'b0;
    if (fire_i) begin
      unique case (item_i.operation)
        OP_TICK: begin
          if (state_i.ms == MS_LAST) begin
            nxt.ms = '0;
            sec    = 1'b1;
            if (state_i.alarm) begin
              nxt.led = ~state_i.led;
            end
            if (state_i.cd_run) begin
              nxt.timer[TM_DOWN] = dn.t;
              if (dn.zero) begin
                nxt.led    = 1'b0;
                nxt.cd_run = 1'b0;
                nxt.alarm  = ~nxt.alarm;
              end
            end
            if (state_i.cu_run) begin
              nxt.timer[TM_UP] = up;
            end
            if (state_i.turn == TURN_P1) begin
              nxt.timer[TM_P1] = p1.t;
              if (p1.zero) begin
                nxt.alarm = ~nxt.alarm;
                nxt.turn  = TURN_EXPIRED;
              end
            end else if (state_i.turn == TURN_P2) begin
              nxt.timer[TM_P2] = p2.t;
              if (p2.zero) begin
                nxt.alarm = ~nxt.alarm;
                nxt.turn  = TURN_EXPIRED;
              end
            end
          end else begin
            nxt.ms = state_i.ms + MS_W'(1);
          end
        end
        OP_CTRL: begin
          nxt.cu_run = item_i.set_countup_run;
          nxt.cd_run = item_i.set_countdown_run;
          nxt.turn   = item_i.set_turn;
          nxt.alarm  = item_i.set_alarm;
        end
        OP_LOAD: begin
          nxt.timer[item_i.timer_select] = '{hours:   item_i.load_hours,
                                             minutes: item_i.load_minutes,
                                             seconds: item_i.load_seconds};
        end
        OP_READ: begin
        end
        default: begin
        end
      endcase
    end
  end

  assign sel_t   = nxt.timer[item_i.timer_select];
  assign state_o = nxt;

  always_comb begin
    result_o.out_hours         = sel_t.hours;
    result_o.out_minutes       = sel_t.minutes;
    result_o.out_seconds       = sel_t.seconds;
    result_o.alarm_active      = nxt.alarm;
    result_o.led_on            = nxt.led;
    result_o.countdown_running = nxt.cd_run;
    result_o.turn_now          = nxt.turn;
    result_o.second_elapsed    = sec;
  end

endmodule

[rtl/core/hms_timers_with_chess_clock.sv]
// ----------------------------------------------------------------------------
// hms_timers_with_chess_clock: hh:mm:ss timers with chess clock
// Count-up clock, countdown timer and two chess clocks on a ms prescaler.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries request transactions: a millisecond tick, a control flag
//   write, a time load into one timer, or a timer readback.
//   out_o returns exactly one response per request, in order: the selected
//   timer, alarm, LED, countdown run flag, chess turn, and a flag for a tick
//   that closed a second.
//   A request passes through one input register, then the state update and
//   the response register before its response is valid.
//   One transaction per cycle is accepted while out_o is not stalled; the
//   state update between the two registers is combinational.
//   Reset clears all timers, flags and the prescaler, and sets the chess
//   turn to idle; no responses are pending after reset.
//   When the receiver stalls, the response register holds and the input
//   register fills; in_i.ready then drops until out_o is taken. State only
//   advances when a request moves into the response register.
// ----------------------------------------------------------------------------
module hms_timers_with_chess_clock (
  input  logic    clk_i,
  input  logic    rst_ni,
  hms_in_if.sink  in_i,
  hms_out_if.source out_o
);
  import hms_pkg::*;

  logic       s1_valid_q, s1_valid_d;
  hms_in_t    s1_item_q;
  logic       out_valid_q, out_valid_d;
  hms_out_t   out_data_q;
  hms_state_t state_q, state_d;
  hms_out_t   result;
  logic       out_load;
  logic       s1_fire;
  logic       in_fire;

  assign out_load   = !out_valid_q || out_o.ready;
  assign s1_fire    = s1_valid_q && out_load;
  assign in_i.ready = !s1_valid_q || out_load;
  assign in_fire    = in_i.valid && in_i.ready;

  assign s1_valid_d  = in_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_q);
  assign out_valid_d = s1_fire ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);

  hms_step u_step (
    .fire_i   (s1_fire),
    .item_i   (s1_item_q),
    .state_i  (state_q),
    .state_o  (state_d),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '{ms: '0, timer: '0, cu_run: 1'b0, cd_run: 1'b0,
                       turn: TURN_IDLE, alarm: 1'b0, led: 1'b0};
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      state_q     <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_item_q <= in_i.data;
    end
    if (s1_fire) begin
      out_data_q <= result;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

`ifndef SYNTHESIS
  a_ms_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.ms <= MS_LAST)
    else $error("prescaler beyond last tick");

  a_sec_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && result.second_elapsed) |=> (state_q.ms == '0))
    else $error("second closed without prescaler wrap");

  a_expired_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.turn == TURN_EXPIRED && !(s1_fire && s1_item_q.operation == OP_CTRL))
    |=> (state_q.turn == TURN_EXPIRED))
    else $error("expired turn left without control write");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |=> $stable(out_data_q))
    else $error("pending response overwritten");
`endif

endmodule
